// ----- src/idgr_pkg.sv -----
`default_nettype none

package idgr_pkg;

  // Fixed widths of the stream fields and registers.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ELEM_W    = 8;
  localparam int unsigned SHIFT_W   = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 8;

  // Fraction bits of the integer sigmoid term.
  localparam int unsigned FRAC_BITS = 14;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ERF_OFFSET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERF_BIAS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMOID_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REQUANT_MULT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REQUANT_SHIFT  = 3'd4;

  // Controller states: accumulate, then one state per epilogue step.
  typedef enum logic [3:0] {
    ST_ACC,
    ST_ABS,
    ST_SQ,
    ST_SIG,
    ST_SGM,
    ST_GM,
    ST_RQ,
    ST_MAG,
    ST_OUT
  } state_t;

  // Step enables from the controller to the datapath.
  typedef struct packed {
    logic mac;
    logic abs_step;
    logic sq_step;
    logic sig_step;
    logic sgm_step;
    logic gm_step;
    logic rq_step;
    logic mag_step;
    logic load_out;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/idgr_ctrl.sv -----
`default_nettype none

module idgr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire logic          s_tlast,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output idgr_pkg::cmd_t     cmd
);
  import idgr_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   in_beat;
  logic   out_free;

  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_ACC);
  assign m_tvalid = out_valid;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC: if (in_beat && s_tlast) state_next = ST_ABS;
      ST_ABS: state_next = ST_SQ;
      ST_SQ:  state_next = ST_SIG;
      ST_SIG: state_next = ST_SGM;
      ST_SGM: state_next = ST_GM;
      ST_GM:  state_next = ST_RQ;
      ST_RQ:  state_next = ST_MAG;
      ST_MAG: state_next = ST_OUT;
      ST_OUT: if (out_free) state_next = ST_ACC;
      default: state_next = ST_ACC;
    endcase
  end

  // Step enables.
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_ACC: cmd.mac      = in_beat;
      ST_ABS: cmd.abs_step = 1'b1;
      ST_SQ:  cmd.sq_step  = 1'b1;
      ST_SIG: cmd.sig_step = 1'b1;
      ST_SGM: cmd.sgm_step = 1'b1;
      ST_GM:  cmd.gm_step  = 1'b1;
      ST_RQ:  cmd.rq_step  = 1'b1;
      ST_MAG: cmd.mag_step = 1'b1;
      ST_OUT: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || m_tready))
    else $error("result register loaded while full");

  // At most one datapath step is enabled in any cycle.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath step enabled");

  // The last beat of a run starts the epilogue.
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_tlast) |=> (state == ST_ABS))
    else $error("epilogue did not start after last beat");

  // The finished result waits in the final step until the output frees.
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !cmd.load_out) |=> (state == ST_OUT))
    else $error("result dropped while output full");

endmodule

`default_nettype wire

// ----- src/idgr_dp.sv -----
`default_nettype none

module idgr_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire idgr_pkg::cmd_t                       cmd,
  input  wire logic                                 cfg_we,
  input  wire logic [idgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [idgr_pkg::DATA_W-1:0]          cfg_data,
  input  wire logic [idgr_pkg::S_TDATA_W-1:0]       s_tdata,
  input  wire logic                                 s_tuser,
  output logic [idgr_pkg::M_TDATA_W-1:0]            m_tdata,
  output logic                                      m_tuser
);
  import idgr_pkg::*;

  // Configuration registers.
  logic [DATA_W-1:0]  erf_offset;
  logic [DATA_W-1:0]  erf_bias;
  logic [DATA_W-1:0]  sigmoid_offset;
  logic [DATA_W-1:0]  requant_mult;
  logic [SHIFT_W-1:0] requant_shift;

  // Accumulator and epilogue pipeline registers.
  logic [DATA_W-1:0]   accumulator;
  logic                neg;
  logic [DATA_W-1:0]   t_val;
  logic [DATA_W-1:0]   sq_val;
  logic [DATA_W-1:0]   y_val;
  logic [DATA_W-1:0]   h_val;
  logic [DATA_W-1:0]   g_val;
  logic signed [2*DATA_W-1:0] p_val;
  logic                p_neg;
  logic [2*DATA_W-1:0] mag;

  // Combinational terms of each step.
  logic signed [ELEM_W-1:0]   a_value;
  logic signed [ELEM_W-1:0]   b_value;
  logic [DATA_W-1:0]          bias_value;
  logic signed [2*ELEM_W-1:0] prod;
  logic [DATA_W-1:0]          acc_base;
  logic [DATA_W-1:0]          ax;
  logic [DATA_W-1:0]          lim;
  logic [DATA_W-1:0]          a_clip;
  logic [DATA_W-1:0]          y_sum;
  logic [DATA_W-1:0]          y_adj;
  logic [DATA_W-1:0]          sg;
  logic signed [2*DATA_W-1:0] p_next;
  logic [2*DATA_W-1:0]        p_abs;
  logic                       sat;
  logic [ELEM_W-1:0]          q_val;

  assign a_value    = s_tdata[ELEM_W-1:0];
  assign b_value    = s_tdata[2*ELEM_W-1:ELEM_W];
  assign bias_value = s_tdata[2*ELEM_W+DATA_W-1:2*ELEM_W];

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      erf_offset     <= '0;
      erf_bias       <= '0;
      sigmoid_offset <= '0;
      requant_mult   <= '0;
      requant_shift  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ERF_OFFSET:     erf_offset     <= cfg_data;
        REG_ERF_BIAS:       erf_bias       <= cfg_data;
        REG_SIGMOID_OFFSET: sigmoid_offset <= cfg_data;
        REG_REQUANT_MULT:   requant_mult   <= cfg_data;
        REG_REQUANT_SHIFT:  requant_shift  <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Multiply-accumulate of one beat.
  assign prod     = a_value * b_value;
  assign acc_base = s_tuser ? bias_value : accumulator;

  // Sign, absolute value and clip against the negated offset.
  assign ax     = accumulator[DATA_W-1] ? (DATA_W'(0) - accumulator) : accumulator;
  assign lim    = DATA_W'(0) - erf_offset;
  assign a_clip = ($signed(ax) < $signed(lim)) ? ax : lim;

  // Constant term, then the sign of the input.
  assign y_sum = sq_val + erf_bias;

  // Arithmetic shift with a bias on negative values rounds toward zero.
  assign y_adj = y_val + (y_val[DATA_W-1] ? DATA_W'((1 << FRAC_BITS) - 1) : DATA_W'(0));
  assign sg    = {{FRAC_BITS{y_adj[DATA_W-1]}}, y_adj[DATA_W-1:FRAC_BITS]};

  // Full signed product for requantization.
  assign p_next = $signed(g_val) * $signed(requant_mult);
  assign p_abs  = p_val[2*DATA_W-1] ? ((2*DATA_W)'(0) - p_val) : p_val;

  // Saturation of the shifted magnitude to int8.
  always_comb begin
    if (p_neg) begin
      sat   = (mag > (2*DATA_W)'(128));
      q_val = sat ? 8'h80 : (ELEM_W'(0) - mag[ELEM_W-1:0]);
    end else begin
      sat   = (mag > (2*DATA_W)'(127));
      q_val = sat ? 8'h7f : mag[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
    end else if (cmd.mac) begin
      accumulator <= acc_base + {{(DATA_W-2*ELEM_W){prod[2*ELEM_W-1]}}, prod};
    end
  end

  // Epilogue pipeline registers, one step enabled at a time.
  always_ff @(posedge clk) begin
    if (cmd.abs_step) begin
      neg   <= accumulator[DATA_W-1];
      t_val <= a_clip + erf_offset;
    end
    if (cmd.sq_step) begin
      sq_val <= t_val * t_val;
    end
    if (cmd.sig_step) begin
      y_val <= neg ? (DATA_W'(0) - y_sum) : y_sum;
    end
    if (cmd.sgm_step) begin
      h_val <= sg + sigmoid_offset;
    end
    if (cmd.gm_step) begin
      g_val <= accumulator * h_val;
    end
    if (cmd.rq_step) begin
      p_val <= p_next;
    end
    if (cmd.mag_step) begin
      p_neg <= p_val[2*DATA_W-1];
      mag   <= p_abs >> requant_shift;
    end
    if (cmd.load_out) begin
      m_tdata <= q_val;
      m_tuser <= sat;
    end
  end

endmodule

`default_nettype wire

// ----- src/int8_dot_gelu_requant.sv -----
// Accumulation takes one beat per cycle with no gaps inside a run.
// After the last beat of a run, the epilogue (clip, square, sigmoid,
// two 32x32 multiplies, shift, saturate) holds s_tready low.
// m_tvalid rises when the epilogue has loaded the result into the output register.
// A result waits in the output register; the next run accumulates meanwhile.
// Synchronous reset clears the configuration registers, the accumulator and the control state.
`default_nettype none

module int8_dot_gelu_requant (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration write port.
  input  wire logic                               cfg_we,
  input  wire logic [idgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [idgr_pkg::DATA_W-1:0]        cfg_data,
  // Input stream.
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [idgr_pkg::S_TDATA_W-1:0]     s_tdata,  // a_value, b_value, bias_value
  input  wire logic                               s_tuser,  // first_term
  input  wire logic                               s_tlast,  // last_term
  // Output stream.
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [idgr_pkg::M_TDATA_W-1:0]          m_tdata,  // gelu_result
  output logic                                    m_tuser   // saturated
);
  import idgr_pkg::*;

  cmd_t cmd;

  idgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  idgr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire
